[src/ils_pkg.sv]
// shared types, widths and codes of the indexed list store
package ils_pkg;

   localparam int DEPTH         = 256;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int REQ_TYPE_W    = 3;
   localparam int POS_W         = 8;
   localparam int WORD_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 9;
   localparam int GATHER_GROUP  = 16;
   localparam int GATHER_GROUPS = DEPTH / GATHER_GROUP;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_GET    = 3'd2,
      OP_INSERT = 3'd3,
      OP_REMOVE = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what each cell of the row does in the transfer cycle
   typedef enum logic [1:0] {
      ACT_HOLD  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_OPEN  = 2'd2,
      ACT_CLOSE = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_GATHER = 2'd1,
      FSM_SEND   = 2'd2
   } fsm_type;

   // command broadcast to every cell
   typedef struct packed {
      act_type                   act;
      logic [IDX_W-1:0]          at;
      logic                      rd_en;
      logic [IDX_W-1:0]          rd_at;
      logic signed [WORD_W-1:0]  word;
   } cmd_type;

endpackage

[src/ils_req_if.sv]
// request and response channel interfaces
interface ils_req_if import ils_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_W-1:0]    req_type;
   logic [POS_W-1:0]         position;
   logic signed [WORD_W-1:0] word_in;

   modport source (output valid, req_type, position, word_in, input ready);
   modport sink   (input valid, req_type, position, word_in, output ready);
endinterface

interface ils_rsp_if import ils_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] word_out;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       count_after;

   modport source (output valid, word_out, status, count_after, input ready);
   modport sink   (input valid, word_out, status, count_after, output ready);
endinterface

[src/indexed_list_store.sv]
// top level of the indexed list store: decode, cell row, read tree, response
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | req_type, position, word_in
//   rsp     | out | valid / ready | word_out, status, count_after
//
// one request in flight. In the transfer cycle the cell row shifts and the
// first or-tree level captures; the combinational second or-tree level
// then feeds the response register.
// req.ready is low from transfer until the response transfer; a stalled
// rsp.ready holds the response and the block.
// synchronous reset clears the count and the control state and holds
// req.ready low; cell contents stay undefined until written.
module indexed_list_store import ils_pkg::*; (
   input logic clock,
   input logic reset,
   ils_req_if.sink   req,
   ils_rsp_if.source rsp
);

   fsm_type                  state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [WORD_W-1:0] word_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic                     accept;
   logic                     rsp_done;
   logic                     load_word;
   cmd_type                  cmd;
   logic [CNT_W-1:0]         pos_ext;
   logic                     full;
   logic signed [WORD_W-1:0] cell_word [DEPTH];
   logic signed [WORD_W-1:0] leaf      [DEPTH];
   logic signed [WORD_W-1:0] gathered;

   assign accept   = req.valid && req.ready;
   assign rsp_done = rsp.valid && rsp.ready;
   assign pos_ext  = CNT_W'(req.position);
   assign full     = (cnt_ff == CNT_W'(DEPTH));

   // request decode into a cell command, status and next count
   always_comb begin
      cmd.act   = ACT_HOLD;
      cmd.at    = req.position[IDX_W-1:0];
      cmd.rd_en = 1'b0;
      cmd.rd_at = req.position[IDX_W-1:0];
      cmd.word  = req.word_in;
      status_in = ST_DONE;
      cnt_in    = cnt_ff;
      unique case (req.req_type)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.act = ACT_WRITE;
               cmd.at  = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (cnt_ff == '0) begin
               status_in = ST_RANGE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_at = IDX_W'(cnt_ff - CNT_W'(1));
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         OP_GET: begin
            if (pos_ext >= cnt_ff) status_in = ST_RANGE;
            else                   cmd.rd_en = 1'b1;
         end
         OP_INSERT: begin
            if (pos_ext > cnt_ff) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.act = ACT_OPEN;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_ext >= cnt_ff) begin
               status_in = ST_RANGE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.act   = ACT_CLOSE;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         default: status_in = ST_RANGE;
      endcase
      // nothing moves without a transfer
      if (!accept) begin
         cmd.act   = ACT_HOLD;
         cmd.rd_en = 1'b0;
      end
   end

   // the row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_w;
      logic signed [WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end
      ils_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[i]),
         .leaf       (leaf[i])
      );
   end

   ils_gather u_gather (
      .clock  (clock),
      .leaf   (leaf),
      .result (gathered)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:   if (accept) state_in = FSM_GATHER;
         FSM_GATHER: state_in = FSM_SEND;
         FSM_SEND:   if (rsp_done) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      load_word = 1'b0;
      unique case (state_ff)
         FSM_IDLE:   req.ready = !reset;
         FSM_GATHER: load_word = 1'b1;
         FSM_SEND:   rsp.valid = 1'b1;
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) cnt_ff <= cnt_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         count_ff  <= COUNT_W'(cnt_in);
      end
      if (load_word) word_ff <= gathered;
   end

   assign rsp.word_out    = word_ff;
   assign rsp.status      = status_ff;
   assign rsp.count_after = count_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp.valid)
      else $error("response not ready two cycles after transfer");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cnt_ff))
      else $error("count changed without a request transfer");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != ST_DONE)) |-> (rsp.word_out == '0))
      else $error("failed request returned a non-zero word");

endmodule

[src/ils_cell.sv]
// one storage cell of the list row, shifting with its neighbours
module ils_cell import ils_pkg::*; (
   input  logic                     clock,
   input  logic [IDX_W-1:0]         cell_idx,
   input  cmd_type                  cmd,
   input  logic signed [WORD_W-1:0] left_word,
   input  logic signed [WORD_W-1:0] right_word,
   output logic signed [WORD_W-1:0] word,
   output logic signed [WORD_W-1:0] leaf
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic                     is_at;
   logic                     is_above;

   assign is_at    = (cell_idx == cmd.at);
   assign is_above = (cell_idx > cmd.at);

   // next word from the broadcast command
   always_comb begin
      word_in = word_ff;
      unique case (cmd.act)
         ACT_WRITE: begin
            if (is_at) word_in = cmd.word;
         end
         ACT_OPEN: begin
            if (is_at)         word_in = cmd.word;
            else if (is_above) word_in = left_word;
         end
         ACT_CLOSE: begin
            if (is_at || is_above) word_in = right_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // drive the read bus only when addressed
   assign leaf = (cmd.rd_en && (cell_idx == cmd.rd_at)) ? word_ff : '0;

endmodule

[src/ils_gather.sv]
// registered or-tree that collects the addressed cell word
module ils_gather import ils_pkg::*; (
   input  logic                     clock,
   input  logic signed [WORD_W-1:0] leaf [DEPTH],
   output logic signed [WORD_W-1:0] result
);

   logic [WORD_W-1:0] grp_ff [GATHER_GROUPS];
   logic [WORD_W-1:0] grp_in [GATHER_GROUPS];
   logic [WORD_W-1:0] top_or;

   // first level: or within each group
   always_comb begin
      for (int g = 0; g < GATHER_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GATHER_GROUP; k++) begin
            grp_in[g] = grp_in[g] | leaf[g*GATHER_GROUP + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GATHER_GROUPS; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   // second level: or across the groups
   always_comb begin
      top_or = '0;
      for (int g = 0; g < GATHER_GROUPS; g++) begin
         top_or = top_or | grp_ff[g];
      end
   end

   assign result = signed'(top_or);

endmodule
